// File: hdl/rie_pkg.sv
// ----------------------------------------------------------------------------
// rie_pkg
// Types, opcodes and memory geometry shared by the execute unit modules.
// ----------------------------------------------------------------------------
package rie_pkg;

    localparam int MEM_BYTES = 1024;
    localparam int MEM_ROWS  = MEM_BYTES / 4;
    localparam int ROW_W     = $clog2(MEM_ROWS);

    localparam logic [31:0] MEM_BYTES_W      = 32'(MEM_BYTES);
    localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;
    localparam logic [31:0] HALF_LANE_MASK   = 32'h0000_FF00;
    localparam logic [31:0] BYTE_LANE_MASK   = 32'h0000_00FF;
    localparam logic [4:0]  LINK_REG         = 5'd31;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_AND  = 5'd2,  OP_OR   = 5'd3,
        OP_XOR  = 5'd4,  OP_NOR  = 5'd5,  OP_NAND = 5'd6,  OP_SLT  = 5'd7,
        OP_SLL  = 5'd8,  OP_SRL  = 5'd9,  OP_SRA  = 5'd10, OP_JR   = 5'd11,
        OP_ADDI = 5'd12, OP_LW   = 5'd13, OP_LH   = 5'd14, OP_LHU  = 5'd15,
        OP_LB   = 5'd16, OP_LBU  = 5'd17, OP_SW   = 5'd18, OP_SH   = 5'd19,
        OP_SB   = 5'd20, OP_LUI  = 5'd21, OP_ANDI = 5'd22, OP_ORI  = 5'd23,
        OP_NORI = 5'd24, OP_SLTI = 5'd25, OP_BEQ  = 5'd26, OP_BNE  = 5'd27,
        OP_J    = 5'd28, OP_JAL  = 5'd29
    } t_op;

    typedef enum logic [2:0] {
        LD_NONE, LD_WORD, LD_HALF, LD_HALFU, LD_BYTE, LD_BYTEU
    } t_ld;

    typedef struct packed {
        t_op         op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [25:0] imm;
    } t_instr;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        wr;
        logic [4:0]  widx;
        logic [31:0] wval;
        t_ld         ld;
        logic [1:0]  off;
        logic        novf;
        logic        zerr;
        logic        aovf;
        logic        mis;
        logic        halted;
    } t_result;

    typedef struct packed {
        logic             wr;
        logic             rd;
        logic [ROW_W-1:0] row;
        logic [3:0]       be;
        logic [31:0]      wdata;
    } t_mem_req;

    function automatic logic add_ovf(input logic [31:0] a, input logic [31:0] b,
                                     input logic [31:0] s);
        logic a_pos, b_pos, s_pos;
        a_pos = (a != 32'd0) && !a[31];
        b_pos = (b != 32'd0) && !b[31];
        s_pos = (s != 32'd0) && !s[31];
        return (a_pos && b_pos && !s_pos) || (a[31] && b[31] && !s[31]);
    endfunction

endpackage

// File: hdl/rie_regfile.sv
// ----------------------------------------------------------------------------
// rie_regfile
// 32 x 32 register file, two registered read ports, one write port.
// ----------------------------------------------------------------------------
module rie_regfile
    import rie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd_en,
    input  logic [4:0]  i_ra,
    input  logic [4:0]  i_rb,
    input  logic        i_wr_en,
    input  logic [4:0]  i_widx,
    input  logic [31:0] i_wdata,
    output logic [31:0] o_qa,
    output logic [31:0] o_qb
);

    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_qa;
    logic [31:0] r_qb;

    // Entries read as zero until first written, so reset needs no sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_widx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_widx] <= i_wdata;
        end
    end

    // A write landing on the same edge is passed straight to the reader.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_qa <= (i_wr_en && i_widx == i_ra) ? i_wdata :
                    (r_vld[i_ra] ? r_mem[i_ra] : 32'd0);
            r_qb <= (i_wr_en && i_widx == i_rb) ? i_wdata :
                    (r_vld[i_rb] ? r_mem[i_rb] : 32'd0);
        end
    end

    assign o_qa = r_qa;
    assign o_qb = r_qb;

endmodule

// File: hdl/rie_dmem.sv
// ----------------------------------------------------------------------------
// rie_dmem
// Word-organized data memory with byte enables and a clearing sweep at reset.
// ----------------------------------------------------------------------------
module rie_dmem
    import rie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mem_req    i_req,
    output logic [31:0] o_rdata,
    output logic        o_busy
);

    logic [31:0]      r_mem [MEM_ROWS];
    logic [31:0]      r_rdata;
    logic             r_clr_busy;
    logic [ROW_W-1:0] r_clr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_row == ROW_W'(MEM_ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_row <= r_clr_row + 1'b1;
        end
    end

    // Byte lane 0 holds the lowest address (bits 31:24), big-endian.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_row] <= 32'd0;
        end else if (i_req.wr) begin
            for (int k = 0; k < 4; k++) begin
                if (i_req.be[3-k]) begin
                    r_mem[i_req.row][31-8*k -: 8] <= i_req.wdata[31-8*k -: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.row];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

// File: hdl/rie_exec.sv
// ----------------------------------------------------------------------------
// rie_exec
// Combinational execute: result, next PC, flags and data memory request.
// ----------------------------------------------------------------------------
module rie_exec
    import rie_pkg::*;
(
    input  t_instr      i_instr,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_pc,
    input  logic        i_stopped,
    output t_result     o_res,
    output t_mem_req    o_mreq
);

    logic [31:0] simm, zimm, pc4, sum_add, neg_b, sum_sub, addr, br_off, br_tgt;
    logic [31:0] lim;
    logic        sz_word, sz_half, fault, take;
    t_result     res;
    t_mem_req    mreq;

    always_comb begin
        simm    = {{16{i_instr.imm[15]}}, i_instr.imm[15:0]};
        zimm    = {16'd0, i_instr.imm[15:0]};
        pc4     = i_pc + 32'd4;
        sum_add = i_a + i_b;
        neg_b   = 32'd0 - i_b;
        sum_sub = i_a + neg_b;
        addr    = i_a + simm;
        br_off  = {simm[29:0], 2'b00};
        br_tgt  = pc4 + br_off;
        sz_word = (i_instr.op == OP_LW) || (i_instr.op == OP_SW);
        sz_half = (i_instr.op == OP_LH) || (i_instr.op == OP_LHU) || (i_instr.op == OP_SH);
        lim     = sz_word ? MEM_BYTES_W - 32'd4 :
                  (sz_half ? MEM_BYTES_W - 32'd2 : MEM_BYTES_W - 32'd1);
        take    = (i_instr.op == OP_BEQ) ? (i_a == i_b) : (i_a != i_b);

        res         = '0;
        res.next_pc = pc4;
        res.ld      = LD_NONE;
        res.off     = addr[1:0];
        res.zerr    = (i_instr.op inside {[OP_ADDI:OP_LBU], [OP_LUI:OP_SLTI]}) &&
                      (i_instr.rt == 5'd0);
        res.aovf    = 1'b0;
        res.mis     = 1'b0;
        fault       = 1'b0;

        mreq       = '0;
        mreq.row   = addr[ROW_W+1:2];
        mreq.wdata = i_b;
        mreq.be    = 4'b1111;

        unique case (i_instr.op)
            OP_ADD: begin
                res.wval = sum_add;
                res.novf = add_ovf(i_a, i_b, sum_add);
                res.widx = i_instr.rd;
                res.wr   = 1'b1;
            end
            OP_SUB: begin
                res.wval = sum_sub;
                res.novf = add_ovf(i_a, neg_b, sum_sub);
                res.widx = i_instr.rd;
                res.wr   = 1'b1;
            end
            OP_AND, OP_OR, OP_XOR, OP_NOR, OP_NAND, OP_SLT, OP_SLL, OP_SRL, OP_SRA: begin
                res.widx = i_instr.rd;
                res.wr   = 1'b1;
                case (i_instr.op)
                    OP_AND:  res.wval = i_a & i_b;
                    OP_OR:   res.wval = i_a | i_b;
                    OP_XOR:  res.wval = i_a ^ i_b;
                    OP_NOR:  res.wval = ~(i_a | i_b);
                    OP_NAND: res.wval = ~(i_a & i_b);
                    OP_SLT:  res.wval = {31'd0, $signed(i_a) < $signed(i_b)};
                    OP_SLL:  res.wval = i_b << i_instr.sh;
                    OP_SRL:  res.wval = i_b >> i_instr.sh;
                    default: res.wval = 32'($signed(i_b) >>> i_instr.sh);
                endcase
            end
            OP_JR: res.next_pc = i_a;
            OP_ADDI: begin
                res.wval = addr;
                res.novf = add_ovf(i_a, simm, addr);
                res.widx = i_instr.rt;
                res.wr   = 1'b1;
            end
            OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB: begin
                res.novf = add_ovf(i_a, simm, addr);
                res.aovf = addr[31] || (addr > lim);
                res.mis  = (sz_word && addr[1:0] != 2'b00) || (sz_half && addr[0]);
                fault    = res.aovf || res.mis;
                if (fault) begin
                    res.halted  = 1'b1;
                    res.next_pc = i_pc;
                end else begin
                    case (i_instr.op)
                        OP_SW: mreq.wr = 1'b1;
                        OP_SH: begin
                            mreq.wr    = 1'b1;
                            mreq.wdata = {2{(i_b & HALF_LANE_MASK) >> 8 == 32'd0 ?
                                            {8'd0, i_b[7:0]} : i_b[15:0]}};
                            mreq.be    = addr[1] ? 4'b0011 : 4'b1100;
                        end
                        OP_SB: begin
                            mreq.wr    = 1'b1;
                            mreq.wdata = {4{i_b[7:0] & BYTE_LANE_MASK[7:0]}};
                            mreq.be    = 4'b1000 >> addr[1:0];
                        end
                        default: begin
                            mreq.rd  = 1'b1;
                            res.wr   = 1'b1;
                            res.widx = i_instr.rt;
                            case (i_instr.op)
                                OP_LW:   res.ld = LD_WORD;
                                OP_LH:   res.ld = LD_HALF;
                                OP_LHU:  res.ld = LD_HALFU;
                                OP_LB:   res.ld = LD_BYTE;
                                default: res.ld = LD_BYTEU;
                            endcase
                        end
                    endcase
                end
            end
            OP_LUI, OP_ANDI, OP_ORI, OP_NORI, OP_SLTI: begin
                res.widx = i_instr.rt;
                res.wr   = 1'b1;
                case (i_instr.op)
                    OP_LUI:  res.wval = zimm << 16;
                    OP_ANDI: res.wval = i_a & zimm;
                    OP_ORI:  res.wval = i_a | zimm;
                    OP_NORI: res.wval = ~(i_a | zimm);
                    default: res.wval = {31'd0, $signed(i_a) < $signed(simm)};
                endcase
            end
            OP_BEQ, OP_BNE: begin
                if (take) begin
                    res.novf    = add_ovf(pc4, br_off, br_tgt);
                    res.next_pc = br_tgt;
                end
            end
            OP_J, OP_JAL: begin
                if (i_instr.op == OP_JAL) begin
                    res.widx = LINK_REG;
                    res.wval = pc4;
                    res.wr   = 1'b1;
                end
                res.next_pc = (pc4 & JUMP_REGION_MASK) | {4'd0, i_instr.imm, 2'b00};
            end
            default: ;
        endcase

        // Register zero is hardwired; the write is dropped.
        if (res.wr && res.widx == 5'd0) begin
            res.wr = 1'b0;
        end
        if (!res.wr) begin
            res.widx = 5'd0;
            res.wval = 32'd0;
            res.ld   = LD_NONE;
        end

        if (i_stopped) begin
            res         = '0;
            res.ld      = LD_NONE;
            res.next_pc = i_pc;
            res.halted  = 1'b1;
            mreq.wr     = 1'b0;
            mreq.rd     = 1'b0;
        end
    end

    assign o_res  = res;
    assign o_mreq = mreq;

endmodule

// File: hdl/risc_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// risc_instruction_execute_unit
// Executes one pre-decoded instruction per transfer against a register file,
// a big-endian data memory and the program counter.
// ----------------------------------------------------------------------------
// One instruction is accepted per clock and its result is presented at the
// outputs once it has passed the input register, then the execute register,
// then the result register; the rate is one per clock, limited by output stall
// and by the memory sweep after reset. Results from the result stage are
// forwarded to the execute stage, so dependent instructions, including a load
// followed by its use, issue back to back. After reset the input stays stalled
// while the MEM_BYTES/4 rows (256 by default) of the data memory are swept to
// zero. A memory fault halts the unit until reset; the start address write
// loads the program counter and must be done while idle.
module risc_instruction_execute_unit
    import rie_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [4:0]         i_opcode,
    input  logic [4:0]         i_rs,
    input  logic [4:0]         i_rt,
    input  logic [4:0]         i_rd,
    input  logic [4:0]         i_shift_amount,
    input  logic [25:0]        i_immediate,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_next_pc,
    output logic               o_reg_written,
    output logic [4:0]         o_written_index,
    output logic signed [31:0] o_written_value,
    output logic               o_number_overflow,
    output logic               o_zero_write_error,
    output logic               o_address_overflow,
    output logic               o_misaligned,
    output logic               o_halted
);

    logic        r_v1, r_v2, r_v3;
    t_instr      r_s1, r_s2;
    t_result     r_s3;
    logic [31:0] r_pc;
    logic        r_stopped;

    logic        accept, load2, adv2, out_xfer, clr_busy, rf_we;
    logic [31:0] rf_qa, rf_qb, fwd_a, fwd_b, mem_rdata, s3_val, ld_val;
    t_result     ex_res;
    t_mem_req    ex_mreq, mem_req;

    assign out_xfer   = r_v3 && !i_out_stall;
    assign adv2       = r_v2 && (!r_v3 || !i_out_stall);
    assign load2      = r_v1 && (!r_v2 || adv2);
    assign o_in_stall = clr_busy || (r_v1 && !load2);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (load2) begin
                r_v1 <= 1'b0;
            end
            if (load2) begin
                r_v2 <= 1'b1;
            end else if (adv2) begin
                r_v2 <= 1'b0;
            end
            if (adv2) begin
                r_v3 <= 1'b1;
            end else if (out_xfer) begin
                r_v3 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= '{op: t_op'(i_opcode), rs: i_rs, rt: i_rt, rd: i_rd,
                      sh: i_shift_amount, imm: i_immediate};
        end
        if (load2) begin
            r_s2 <= r_s1;
        end
        if (adv2) begin
            r_s3 <= ex_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= 32'd0;
            r_stopped <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_pc <= i_cfg_wr_data;
        end else if (adv2) begin
            r_pc      <= ex_res.next_pc;
            r_stopped <= ex_res.halted;
        end
    end

    // Register write commits when the result transfers out.
    assign rf_we = out_xfer && r_s3.wr;

    rie_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (load2),
        .i_ra    (r_s1.rs),
        .i_rb    (r_s1.rt),
        .i_wr_en (rf_we),
        .i_widx  (r_s3.widx),
        .i_wdata (s3_val),
        .o_qa    (rf_qa),
        .o_qb    (rf_qb)
    );

    always_comb begin
        case (r_s3.ld)
            LD_WORD:  ld_val = mem_rdata;
            LD_HALF:  ld_val = r_s3.off[1] ? {{16{mem_rdata[15]}}, mem_rdata[15:0]} :
                                             {{16{mem_rdata[31]}}, mem_rdata[31:16]};
            LD_HALFU: ld_val = r_s3.off[1] ? {16'd0, mem_rdata[15:0]} :
                                             {16'd0, mem_rdata[31:16]};
            LD_BYTE, LD_BYTEU: begin
                case (r_s3.off)
                    2'd0:    ld_val = {24'd0, mem_rdata[31:24]};
                    2'd1:    ld_val = {24'd0, mem_rdata[23:16]};
                    2'd2:    ld_val = {24'd0, mem_rdata[15:8]};
                    default: ld_val = {24'd0, mem_rdata[7:0]};
                endcase
                if (r_s3.ld == LD_BYTE) begin
                    ld_val[31:8] = {24{ld_val[7]}};
                end
            end
            default:  ld_val = r_s3.wval;
        endcase
    end

    assign s3_val = r_s3.wr ? ld_val : 32'd0;

    assign fwd_a = (r_v3 && r_s3.wr && r_s3.widx == r_s2.rs) ? s3_val : rf_qa;
    assign fwd_b = (r_v3 && r_s3.wr && r_s3.widx == r_s2.rt) ? s3_val : rf_qb;

    rie_exec u_exec (
        .i_instr   (r_s2),
        .i_a       (fwd_a),
        .i_b       (fwd_b),
        .i_pc      (r_pc),
        .i_stopped (r_stopped),
        .o_res     (ex_res),
        .o_mreq    (ex_mreq)
    );

    always_comb begin
        mem_req    = ex_mreq;
        mem_req.wr = ex_mreq.wr && adv2;
        mem_req.rd = ex_mreq.rd && adv2;
    end

    rie_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata),
        .o_busy  (clr_busy)
    );

    assign o_out_valid        = r_v3;
    assign o_next_pc          = r_s3.next_pc;
    assign o_reg_written      = r_s3.wr;
    assign o_written_index    = r_s3.widx;
    assign o_written_value    = s3_val;
    assign o_number_overflow  = r_s3.novf;
    assign o_zero_write_error = r_s3.zerr;
    assign o_address_overflow = r_s3.aovf;
    assign o_misaligned       = r_s3.mis;
    assign o_halted           = r_s3.halted;

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("halt state was left without reset");

    a_no_zero_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reg_written) |-> (o_written_index != 5'd0))
        else $error("register zero reported as written");

    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_address_overflow || o_misaligned)) |->
        (o_halted && !o_reg_written))
        else $error("memory fault did not halt cleanly");

    a_no_issue_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> (!mem_req.rd && !mem_req.wr && !r_v2))
        else $error("memory access during clearing sweep");
`endif

endmodule

// File: dv/risc_instruction_execute_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// risc_instruction_execute_unit_tb
// Self-checking bench for the execute unit. A directed table of instructions
// is followed by random programs over several start addresses. Every result
// is checked against an in-bench model of the registers, memory and PC; the
// memory fault cases close the run, since a fault halts the unit for good.
// ----------------------------------------------------------------------------
module risc_instruction_execute_unit_tb;
    import rie_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 200;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        wr;
        logic [4:0]  widx;
        logic [31:0] wval;
        logic        novf;
        logic        zerr;
        logic        aovf;
        logic        mis;
        logic        halted;
    } t_exec_out;

    typedef struct {
        logic [4:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [25:0] imm;
        bit          typed;
        t_exec_out   res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [31:0]        i_cfg_wr_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [4:0]         i_opcode = '0;
    logic [4:0]         i_rs = '0;
    logic [4:0]         i_rt = '0;
    logic [4:0]         i_rd = '0;
    logic [4:0]         i_shift_amount = '0;
    logic [25:0]        i_immediate = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [31:0]        o_next_pc;
    logic               o_reg_written;
    logic [4:0]         o_written_index;
    logic signed [31:0] o_written_value;
    logic               o_number_overflow;
    logic               o_zero_write_error;
    logic               o_address_overflow;
    logic               o_misaligned;
    logic               o_halted;

    risc_instruction_execute_unit dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Model state.
    logic [31:0] gpr [32];
    logic [7:0]  dmem [MEM_BYTES];
    logic [31:0] pc_model;
    bit          halt_model;

    t_exec_out   pending_q [$];
    int          errors;
    int          idle_cycles;
    bit          calm;

    function automatic logic [31:0] sext16(input logic [25:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    function automatic logic ovf_of_add(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] s);
        return ((a != 0 && !a[31]) && (b != 0 && !b[31]) && !(s != 0 && !s[31])) ||
               (a[31] && b[31] && !s[31]);
    endfunction

    function automatic int access_size(input logic [4:0] op);
        if (op == OP_LW || op == OP_SW) return 4;
        if (op == OP_LH || op == OP_LHU || op == OP_SH) return 2;
        return 1;
    endfunction

    function automatic bit is_mem_op(input logic [4:0] op);
        return op >= OP_LW && op <= OP_SB;
    endfunction

    function automatic bit access_faults(input logic [31:0] addr, input int size);
        return addr[31] || addr > MEM_BYTES_W - size || (addr & (size - 1)) != 0;
    endfunction

    task automatic execute_model(input logic [4:0] op, input logic [4:0] rs,
                                 input logic [4:0] rt, input logic [4:0] rd,
                                 input logic [4:0] sh, input logic [25:0] imm,
                                 output t_exec_out r);
        logic [31:0] a, b, simm, zimm, npc, v, nb, addr, off;
        int          size;
        a = gpr[rs];
        b = gpr[rt];
        simm = sext16(imm);
        zimm = {16'd0, imm[15:0]};
        npc = pc_model + 4;
        r = '0;
        if (halt_model) begin
            r.next_pc = pc_model;
            r.halted = 1'b1;
            return;
        end
        if (op >= OP_ADDI && op <= OP_SLTI && !(op >= OP_SW && op <= OP_SB) && rt == 0)
            r.zerr = 1'b1;
        case (op)
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOR, OP_NAND, OP_SLT,
            OP_SLL, OP_SRL, OP_SRA: begin
                case (op)
                    OP_ADD: begin v = a + b; r.novf = ovf_of_add(a, b, v); end
                    OP_SUB: begin nb = -b; v = a + nb; r.novf = ovf_of_add(a, nb, v); end
                    OP_AND: v = a & b;
                    OP_OR: v = a | b;
                    OP_XOR: v = a ^ b;
                    OP_NOR: v = ~(a | b);
                    OP_NAND: v = ~(a & b);
                    OP_SLT: v = {31'd0, $signed(a) < $signed(b)};
                    OP_SLL: v = b << sh;
                    OP_SRL: v = b >> sh;
                    default: v = $signed(b) >>> sh;
                endcase
                r.wr = 1'b1; r.widx = rd; r.wval = v;
            end
            OP_JR: npc = a;
            OP_ADDI: begin
                r.wval = a + simm; r.novf = ovf_of_add(a, simm, r.wval);
                r.wr = 1'b1; r.widx = rt;
            end
            OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB: begin
                addr = a + simm;
                size = access_size(op);
                r.novf = ovf_of_add(a, simm, addr);
                r.aovf = addr[31] || addr > MEM_BYTES_W - size;
                r.mis = (addr & (size - 1)) != 0;
                if (r.aovf || r.mis) begin
                    halt_model = 1'b1;
                    npc = pc_model;
                end else begin
                    case (op)
                        OP_LW: r.wval = {dmem[addr], dmem[addr+1], dmem[addr+2], dmem[addr+3]};
                        OP_LH: r.wval = {{16{dmem[addr][7]}}, dmem[addr], dmem[addr+1]};
                        OP_LHU: r.wval = {16'd0, dmem[addr], dmem[addr+1]};
                        OP_LB: r.wval = {{24{dmem[addr][7]}}, dmem[addr]};
                        OP_LBU: r.wval = {24'd0, dmem[addr]};
                        OP_SW: begin
                            dmem[addr] = b[31:24]; dmem[addr+1] = b[23:16];
                            dmem[addr+2] = b[15:8]; dmem[addr+3] = b[7:0];
                        end
                        OP_SH: begin dmem[addr] = b[15:8]; dmem[addr+1] = b[7:0]; end
                        default: dmem[addr] = b[7:0];
                    endcase
                    if (op <= OP_LBU) begin r.wr = 1'b1; r.widx = rt; end
                end
            end
            OP_LUI: begin r.wval = zimm << 16; r.wr = 1'b1; r.widx = rt; end
            OP_ANDI: begin r.wval = a & zimm; r.wr = 1'b1; r.widx = rt; end
            OP_ORI: begin r.wval = a | zimm; r.wr = 1'b1; r.widx = rt; end
            OP_NORI: begin r.wval = ~(a | zimm); r.wr = 1'b1; r.widx = rt; end
            OP_SLTI: begin
                r.wval = {31'd0, $signed(a) < $signed(simm)}; r.wr = 1'b1; r.widx = rt;
            end
            OP_BEQ, OP_BNE: begin
                if ((op == OP_BEQ) == (a == b)) begin
                    off = simm << 2;
                    r.novf = ovf_of_add(npc, off, npc + off);
                    npc = npc + off;
                end
            end
            OP_J, OP_JAL: begin
                if (op == OP_JAL) begin r.wr = 1'b1; r.widx = LINK_REG; r.wval = pc_model + 4; end
                npc = ((pc_model + 4) & JUMP_REGION_MASK) | {4'd0, imm, 2'b00};
            end
            default: ;
        endcase
        if (r.wr && r.widx == 0) r.wr = 1'b0;
        if (r.wr) gpr[r.widx] = r.wval;
        else begin r.widx = '0; r.wval = '0; end
        pc_model = npc;
        r.next_pc = npc;
        r.halted = halt_model;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h, expected %h", field, got, want);
    endtask

    // Drives one instruction and waits for its transfer.
    task automatic issue(input logic [4:0] op, input logic [4:0] rs, input logic [4:0] rt,
                         input logic [4:0] rd, input logic [4:0] sh, input logic [25:0] imm,
                         input bit typed, input t_exec_out typed_res);
        t_exec_out r;
        int        gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op; i_rs <= rs; i_rt <= rt; i_rd <= rd;
        i_shift_amount <= sh; i_immediate <= imm;
        do @(posedge i_clk); while (o_in_stall);
        execute_model(op, rs, rt, rd, sh, imm, r);
        pending_q.push_back(typed ? typed_res : r);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_start(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        pc_model = value;
    endtask

    // Random instruction; memory accesses are steered into range so that the
    // unit does not halt before the fault cases at the end.
    task automatic random_instr();
        logic [4:0]  op, rs, rt, rd, sh;
        logic [25:0] imm;
        logic [31:0] target;
        int          size;
        op = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 2) == 0) op = 5'($urandom_range(OP_LW, OP_SB));
        rs = 5'($urandom_range(0, 31)); rt = 5'($urandom_range(0, 31));
        rd = 5'($urandom_range(0, 31)); sh = 5'($urandom_range(0, 31));
        imm = 26'($urandom);
        if (is_mem_op(op)) begin
            size = access_size(op);
            target = ($urandom_range(0, 1) ? $urandom_range(0, 63)
                                           : $urandom_range(0, MEM_BYTES - 1));
            target = (target & ~(size - 1));
            if (target > MEM_BYTES - size) target = MEM_BYTES - size;
            if (access_faults(gpr[rs] + sext16(imm), size)) begin
                imm[15:0] = 16'(target - gpr[rs]);
                if (access_faults(gpr[rs] + sext16(imm), size)) begin
                    rs = 0;
                    imm[15:0] = target[15:0];
                end
            end
        end
        issue(op, rs, rt, rd, sh, imm, 1'b0, '0);
    endtask

    // Directed program, in order; rows with typed results keep the PC linear.
    t_row dir_rows [] = '{
        '{OP_LUI,  0, 1, 0, 0, 26'h8000, 1, '{32'd4, 1, 1, 32'h8000_0000, 0, 0, 0, 0, 0}},
        '{OP_SUB,  0, 1, 2, 0, 26'h0, 0, '0},
        '{OP_SUB,  1, 1, 3, 0, 26'h0, 0, '0},
        '{OP_ADDI, 0, 4, 0, 0, 26'h7FFF, 1, '{32'd16, 1, 4, 32'h7FFF, 0, 0, 0, 0, 0}},
        '{OP_ADDI, 4, 5, 0, 0, 26'h7FFF, 0, '0},
        '{OP_ADDI, 1, 0, 0, 0, 26'h5, 1, '{32'd24, 0, 0, 32'h0, 0, 1, 0, 0, 0}},
        '{OP_ADD,  1, 1, 5, 0, 26'h0, 0, '0},
        '{OP_NOR,  0, 0, 6, 0, 26'h0, 1, '{32'd32, 1, 6, 32'hFFFF_FFFF, 0, 0, 0, 0, 0}},
        '{OP_SRA,  0, 1, 7, 31, 26'h0, 0, '0},
        '{OP_SLL,  0, 6, 8, 31, 26'h0, 0, '0},
        '{OP_SRL,  0, 1, 9, 31, 26'h0, 1, '{32'd44, 1, 9, 32'h1, 0, 0, 0, 0, 0}},
        '{OP_SW,   0, 1, 0, 0, 26'd1020, 0, '0},
        '{OP_LW,   0, 10, 0, 0, 26'd1020, 0, '0},
        '{OP_LH,   0, 11, 0, 0, 26'd1022, 0, '0},
        '{OP_LHU,  0, 12, 0, 0, 26'd1020, 0, '0},
        '{OP_LB,   0, 13, 0, 0, 26'd1020, 0, '0},
        '{OP_LBU,  0, 14, 0, 0, 26'd1023, 0, '0},
        '{OP_SH,   0, 6, 0, 0, 26'd0, 0, '0},
        '{OP_SB,   0, 4, 0, 0, 26'd3, 0, '0},
        '{OP_LW,   0, 15, 0, 0, 26'd0, 0, '0},
        '{OP_AND,  6, 1, 16, 0, 26'h0, 0, '0},
        '{OP_OR,   4, 1, 17, 0, 26'h0, 0, '0},
        '{OP_XOR,  6, 1, 18, 0, 26'h0, 0, '0},
        '{OP_NAND, 6, 1, 19, 0, 26'h0, 0, '0},
        '{OP_SLT,  1, 4, 20, 0, 26'h0, 0, '0},
        '{OP_ANDI, 6, 21, 0, 0, 26'h3FFFFFF, 0, '0},
        '{OP_ORI,  1, 22, 0, 0, 26'hFFFF, 0, '0},
        '{OP_NORI, 0, 23, 0, 0, 26'h0, 0, '0},
        '{OP_SLTI, 1, 24, 0, 0, 26'h8000, 0, '0},
        '{5'd30,   31, 31, 31, 31, 26'h3FFFFFF, 0, '0},
        '{OP_BEQ,  0, 0, 0, 0, 26'hFFFF, 0, '0},
        '{OP_BNE,  1, 4, 0, 0, 26'h7FFF, 0, '0},
        '{OP_JAL,  0, 0, 0, 0, 26'h3FFFFFF, 0, '0},
        '{OP_J,    0, 0, 0, 0, 26'h0, 0, '0},
        '{OP_JR,   1, 0, 0, 0, 26'h0, 0, '0},
        '{5'd31,   0, 0, 0, 0, 26'h0, 0, '0}
    };

    // Receiver stall: mostly open, with short and occasional long holds.
    int stall_left;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(0, 2);
        end
    end
    always @(negedge i_clk) i_out_stall <= (stall_left > 0);

    always @(posedge i_clk) begin
        t_exec_out want;
        if (o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected transfer", o_next_pc, 32'd0);
            end else begin
                want = pending_q.pop_front();
                if (o_next_pc !== want.next_pc) report_mismatch("next_pc", o_next_pc, want.next_pc);
                if (o_reg_written !== want.wr)
                    report_mismatch("reg_written", 32'(o_reg_written), 32'(want.wr));
                if (o_written_index !== want.widx)
                    report_mismatch("written_index", 32'(o_written_index), 32'(want.widx));
                if (o_written_value !== want.wval)
                    report_mismatch("written_value", o_written_value, want.wval);
                if (o_number_overflow !== want.novf)
                    report_mismatch("number_overflow", 32'(o_number_overflow), 32'(want.novf));
                if (o_zero_write_error !== want.zerr)
                    report_mismatch("zero_write_error", 32'(o_zero_write_error),
                                    32'(want.zerr));
                if (o_address_overflow !== want.aovf)
                    report_mismatch("address_overflow", 32'(o_address_overflow),
                                    32'(want.aovf));
                if (o_misaligned !== want.mis)
                    report_mismatch("misaligned", 32'(o_misaligned), 32'(want.mis));
                if (o_halted !== want.halted)
                    report_mismatch("halted", 32'(o_halted), 32'(want.halted));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    logic [31:0] start_values [5];

    initial begin
        errors = 0;
        idle_cycles = 0;
        calm = 1'b0;
        stall_left = 0;
        foreach (gpr[k]) gpr[k] = '0;
        foreach (dmem[k]) dmem[k] = '0;
        pc_model = '0;
        halt_model = 1'b0;
        start_values = '{32'h0, 32'hFFFF_FFFF, 32'h0000_0400, 32'hFFFF_FFFC, 32'h0};
        start_values[4] = $urandom;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            issue(dir_rows[k].op, dir_rows[k].rs, dir_rows[k].rt, dir_rows[k].rd,
                  dir_rows[k].sh, dir_rows[k].imm, dir_rows[k].typed, dir_rows[k].res);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            write_start(start_values[ph + 1]);
            calm = (ph == 1);
            repeat (PHASE_ITEMS) random_instr();
            settle();
        end
        calm = 1'b0;

        // Memory faults: both flags at once, then nothing changes while halted.
        issue(OP_LW, 0, 3, 0, 0, 26'd1022, 1'b0, '0);
        issue(OP_SB, 0, 0, 0, 0, 26'hFFFF, 1'b0, '0);
        issue(OP_ADDI, 0, 2, 0, 0, 26'h1, 1'b0, '0);
        settle();
        write_start(start_values[0]);
        issue(OP_JAL, 0, 0, 0, 0, 26'h1234, 1'b0, '0);
        issue(OP_LH, 0, 1, 0, 0, 26'hFFFF, 1'b0, '0);
        settle();

        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
